[hdl/sece_pkg.sv]
// Shared types and constants for the SPI EEPROM command engine.
`default_nettype none

package sece_pkg;

  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned PAGE_BYTES = 128;
  localparam int unsigned OFS_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  // Bus item codes
  localparam logic [1:0] CMD_SEND  = 2'd0;
  localparam logic [1:0] CMD_CLOCK = 2'd1;
  localparam logic [1:0] CMD_DESEL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OPC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_OPC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OPC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_OPC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK     = 3'd4;

  localparam logic [7:0] RST_WRITE_OPC  = 8'h02;
  localparam logic [7:0] RST_READ_OPC   = 8'h03;
  localparam logic [7:0] RST_STATUS_OPC = 8'h05;
  localparam logic [7:0] RST_ENABLE_OPC = 8'h06;
  localparam logic [7:0] RST_UNLOCK     = 8'h02;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_AHI  = 5'b00010,
    PH_ALO  = 5'b00100,
    PH_MEM  = 5'b01000,
    PH_STAT = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    OP_LIT = 2'd0,
    OP_WR  = 2'd1,
    OP_RD  = 2'd2
  } op_kind_e;

  // One classified item handed from front to back
  typedef struct packed {
    op_kind_e             kind;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           data;
  } op_t;

endpackage

`default_nettype wire

[hdl/sece_front.sv]
// Front end: command decode, address/offset tracking, configuration registers.
`default_nettype none

module sece_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [sece_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  input  wire logic                          fire_i,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [7:0]                    data_in_i,
  output sece_pkg::op_t                      op_o
);

  logic [7:0] wr_opc_q, rd_opc_q, st_opc_q, en_opc_q, unlock_q;

  sece_pkg::phase_e              phase_q, phase_d;
  logic                          reading_q, reading_d;
  logic [7:0]                    status_q, status_d;
  logic [7:0]                    addr_hi_q, addr_hi_d;
  logic [7:0]                    addr_lo_q, addr_lo_d;
  logic [sece_pkg::OFS_W-1:0]    offset_q, offset_d;
  logic [sece_pkg::ADDR_BITS-1:0] cur_addr;
  logic [sece_pkg::OFS_W:0]      ofs_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_opc_q <= sece_pkg::RST_WRITE_OPC;
      rd_opc_q <= sece_pkg::RST_READ_OPC;
      st_opc_q <= sece_pkg::RST_STATUS_OPC;
      en_opc_q <= sece_pkg::RST_ENABLE_OPC;
      unlock_q <= sece_pkg::RST_UNLOCK;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sece_pkg::CFG_WRITE_OPC:  wr_opc_q <= cfg_data_i;
        sece_pkg::CFG_READ_OPC:   rd_opc_q <= cfg_data_i;
        sece_pkg::CFG_STATUS_OPC: st_opc_q <= cfg_data_i;
        sece_pkg::CFG_ENABLE_OPC: en_opc_q <= cfg_data_i;
        sece_pkg::CFG_UNLOCK:     unlock_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // base + offset, wrapped to the array size
  assign cur_addr = sece_pkg::ADDR_BITS'(({8'h00, addr_hi_q, addr_lo_q}) +
                                         {8'h00, offset_q});
  assign ofs_inc  = {1'b0, offset_q} + 17'd1;

  always_comb begin
    phase_d   = phase_q;
    reading_d = reading_q;
    status_d  = status_q;
    addr_hi_d = addr_hi_q;
    addr_lo_d = addr_lo_q;
    offset_d  = offset_q;
    op_o.kind = sece_pkg::OP_LIT;
    op_o.addr = cur_addr;
    op_o.data = sece_pkg::IDLE_BYTE;
    unique case (cmd_i)
      sece_pkg::CMD_SEND: begin
        unique case (phase_q)
          sece_pkg::PH_IDLE: begin
            priority if (data_in_i == wr_opc_q) begin
              reading_d = 1'b0;
              phase_d   = sece_pkg::PH_AHI;
            end else if (data_in_i == rd_opc_q) begin
              reading_d = 1'b1;
              phase_d   = sece_pkg::PH_AHI;
            end else if (data_in_i == st_opc_q) begin
              phase_d = sece_pkg::PH_STAT;
            end else if (data_in_i == en_opc_q) begin
              status_d = status_q | unlock_q;
            end else begin
            end
          end
          sece_pkg::PH_AHI: begin
            addr_hi_d = data_in_i;
            phase_d   = sece_pkg::PH_ALO;
          end
          sece_pkg::PH_ALO: begin
            addr_lo_d = data_in_i;
            phase_d   = sece_pkg::PH_MEM;
          end
          sece_pkg::PH_MEM: begin
            if (!reading_q) begin
              op_o.kind = sece_pkg::OP_WR;
              op_o.data = data_in_i;
              // page wrap relative to the start address
              offset_d  = sece_pkg::OFS_W'(ofs_inc % sece_pkg::PAGE_BYTES);
            end
          end
          default: ;
        endcase
      end
      sece_pkg::CMD_CLOCK: begin
        unique case (phase_q)
          sece_pkg::PH_MEM: begin
            if (reading_q) begin
              op_o.kind = sece_pkg::OP_RD;
              offset_d  = ofs_inc[sece_pkg::OFS_W-1:0];
            end
          end
          sece_pkg::PH_STAT: begin
            op_o.data = status_q;
            phase_d   = sece_pkg::PH_IDLE;
          end
          default: ;
        endcase
      end
      sece_pkg::CMD_DESEL: begin
        phase_d  = sece_pkg::PH_IDLE;
        offset_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sece_pkg::PH_IDLE;
      reading_q <= 1'b0;
      status_q  <= 8'h00;
      addr_hi_q <= 8'h00;
      addr_lo_q <= 8'h00;
      offset_q  <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      reading_q <= reading_d;
      status_q  <= status_d;
      addr_hi_q <= addr_hi_d;
      addr_lo_q <= addr_lo_d;
      offset_q  <= offset_d;
    end
  end

endmodule

`default_nettype wire

[hdl/sece_queue.sv]
// Two-entry queue of classified operations between front and back.
`default_nettype none

module sece_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sece_pkg::op_t op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output sece_pkg::op_t      op_o
);

  sece_pkg::op_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign op_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

[hdl/sece_back.sv]
// Back end: EEPROM array access and the output register.
`default_nettype none

module sece_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          op_valid_i,
  input  wire sece_pkg::op_t op_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         read_data_o
);

  logic [7:0] mem_q [2**sece_pkg::ADDR_BITS];
  logic [7:0] rd_data_q;
  logic [7:0] lit_q;
  logic       from_mem_q;
  logic       out_valid_q;

  // issue only when the output slot is free or drains this cycle,
  // so the registered read data never gets overwritten while held
  assign pop_o = op_valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (pop_o && (op_i.kind == sece_pkg::OP_WR)) begin
      mem_q[op_i.addr] <= op_i.data;
    end
    if (pop_o && (op_i.kind == sece_pkg::OP_RD)) begin
      rd_data_q <= mem_q[op_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lit_q      <= (op_i.kind == sece_pkg::OP_LIT) ? op_i.data : sece_pkg::IDLE_BYTE;
      from_mem_q <= op_i.kind == sece_pkg::OP_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = from_mem_q ? rd_data_q : lit_q;

endmodule

`default_nettype wire

[hdl/spi_eeprom_command_engine_top.sv]
// Top level of the SPI EEPROM command engine.
//
//  channel  direction  handshake               payload
//  in       to block   in_valid_i / in_stall_o  cmd_i, data_in_i
//  out      from block out_valid_o/out_stall_i  read_data_o
//  cfg      to block   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output does not stall: front decode goes straight into
// a queue slot register, then one array access goes into the output register.
// The 64K x 8 array takes at most one read or one write per item; it is not cleared by reset.
// Input stalls only when the two-entry queue is full; output stalls back up into it.
// Reset restores the opcode registers to their standard values and the bus state to idle.
`default_nettype none

module spi_eeprom_command_engine_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [7:0]                    data_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         read_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sece_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i
);

  sece_pkg::op_t front_op, queue_op;
  logic          in_fire;
  logic          q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign in_fire     = in_valid_i && !q_full;

  sece_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (in_fire),
    .cmd_i       (cmd_i),
    .data_in_i   (data_in_i),
    .op_o        (front_op)
  );

  sece_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (queue_op)
  );

  sece_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (queue_op),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

endmodule

`default_nettype wire

[verif/tb_spi_eeprom_command_engine_top.sv]
// Testbench for the SPI EEPROM command engine: bus items against a predictor of the chip.
`default_nettype none

module tb_spi_eeprom_command_engine_top;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic       clk        = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid   = 1'b0;
  logic [1:0] in_cmd     = sece_pkg::CMD_DESEL;
  logic [7:0] in_data    = 8'h00;
  logic       out_stall  = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic [sece_pkg::CFG_IDX_W-1:0] cfg_index = sece_pkg::CFG_WRITE_OPC;
  logic [7:0] cfg_data   = 8'h00;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] read_data;
  logic       cfg_ready;

  spi_eeprom_command_engine_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (in_cmd),
    .data_in_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_data_o (read_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Chip state as the host should see it
  logic [7:0]  opc_write   = sece_pkg::RST_WRITE_OPC;
  logic [7:0]  opc_read    = sece_pkg::RST_READ_OPC;
  logic [7:0]  opc_status  = sece_pkg::RST_STATUS_OPC;
  logic [7:0]  opc_enable  = sece_pkg::RST_ENABLE_OPC;
  logic [7:0]  unlock_bits = sece_pkg::RST_UNLOCK;
  sece_pkg::phase_e bus_phase = sece_pkg::PH_IDLE;
  logic        reading     = 1'b0;
  logic [7:0]  status_q    = 8'h00;
  logic [7:0]  addr_hi     = 8'h00;
  logic [7:0]  addr_lo     = 8'h00;
  logic [15:0] offset      = 16'h0000;
  logic [7:0]  mem_image [0:65535];
  bit          mem_valid [0:65535];

  logic [7:0]  expected_read_data [$];
  logic [15:0] write_starts [$];

  int unsigned items_sent   = 0;
  int unsigned bytes_check  = 0;
  int unsigned reg_writes   = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_held      = 0;
  bit          tx_gaps      = 1'b0;
  bit          rx_gaps      = 1'b0;
  bit          hold_go      = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned burst_left   = 0;

  function automatic logic [15:0] access_addr();
    return {addr_hi, addr_lo} + offset;
  endfunction

  function automatic bit would_read_unwritten();
    return bus_phase == sece_pkg::PH_MEM && reading && !mem_valid[access_addr()];
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] predict_read_data(input logic [1:0] cmd,
                                                   input logic [7:0] din);
    logic [7:0]  rd;
    logic [15:0] a;
    rd = sece_pkg::IDLE_BYTE;
    a  = access_addr();
    case (cmd)
      sece_pkg::CMD_SEND: begin
        case (bus_phase)
          sece_pkg::PH_IDLE: begin
            if (din == opc_write) begin
              reading   = 1'b0;
              bus_phase = sece_pkg::PH_AHI;
            end else if (din == opc_read) begin
              reading   = 1'b1;
              bus_phase = sece_pkg::PH_AHI;
            end else if (din == opc_status) begin
              bus_phase = sece_pkg::PH_STAT;
            end else if (din == opc_enable) begin
              status_q = status_q | unlock_bits;
            end
          end
          sece_pkg::PH_AHI: begin
            addr_hi   = din;
            bus_phase = sece_pkg::PH_ALO;
          end
          sece_pkg::PH_ALO: begin
            addr_lo   = din;
            bus_phase = sece_pkg::PH_MEM;
          end
          sece_pkg::PH_MEM: begin
            if (!reading) begin
              mem_image[a] = din;
              mem_valid[a] = 1'b1;
              // write offset stays inside the page, relative to the start address
              offset = 16'((offset + 1) % sece_pkg::PAGE_BYTES);
            end
          end
          default: ;
        endcase
      end
      sece_pkg::CMD_CLOCK: begin
        if (bus_phase == sece_pkg::PH_MEM && reading) begin
          rd     = mem_image[a];
          offset = offset + 16'd1;
        end else if (bus_phase == sece_pkg::PH_STAT) begin
          rd        = status_q;
          bus_phase = sece_pkg::PH_IDLE;
        end
      end
      sece_pkg::CMD_DESEL: begin
        bus_phase = sece_pkg::PH_IDLE;
        offset    = 16'h0000;
      end
      default: ;
    endcase
    return rd;
  endfunction

  // One bus transfer; a clock-out that would hit a never-written byte goes out as the unused code
  task automatic bus_item(input logic [1:0] cmd, input logic [7:0] din);
    logic [1:0] c;
    c = cmd;
    if (c == sece_pkg::CMD_CLOCK && would_read_unwritten()) c = CMD_UNUSED;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_cmd   = c;
    in_data  = din;
    do @(posedge clk); while (in_stall);
    expected_read_data.push_back(predict_read_data(c, din));
    items_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_read_data.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [sece_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sece_pkg::CFG_WRITE_OPC:  opc_write   = val;
      sece_pkg::CFG_READ_OPC:   opc_read    = val;
      sece_pkg::CFG_STATUS_OPC: opc_status  = val;
      sece_pkg::CFG_ENABLE_OPC: opc_enable  = val;
      sece_pkg::CFG_UNLOCK:     unlock_bits = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic to_idle();
    if (bus_phase != sece_pkg::PH_IDLE || $urandom_range(0, 7) == 0) begin
      bus_item(sece_pkg::CMD_DESEL, rnd_byte());
    end
  endtask

  function automatic logic [15:0] pick_start();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return 16'($urandom_range(0, 1023));
    if (k < 85) return 16'hFF00 + 16'($urandom_range(0, 255));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_read_start();
    if (write_starts.size() == 0) return pick_start();
    return write_starts[$urandom_range(0, write_starts.size() - 1)] +
           16'($urandom_range(0, 7));
  endfunction

  task automatic write_burst(input logic [15:0] start, input int len);
    to_idle();
    bus_item(sece_pkg::CMD_SEND, opc_write);
    bus_item(sece_pkg::CMD_SEND, start[15:8]);
    bus_item(sece_pkg::CMD_SEND, start[7:0]);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) bus_item(sece_pkg::CMD_CLOCK, rnd_byte());
      bus_item(sece_pkg::CMD_SEND, rnd_byte());
    end
    if (len > 0) write_starts.push_back(start);
    bus_item(sece_pkg::CMD_DESEL, rnd_byte());
  endtask

  task automatic read_burst(input logic [15:0] start, input int len);
    to_idle();
    bus_item(sece_pkg::CMD_SEND, opc_read);
    bus_item(sece_pkg::CMD_SEND, start[15:8]);
    bus_item(sece_pkg::CMD_SEND, start[7:0]);
    for (int i = 0; i < len; i++) begin
      if (would_read_unwritten()) break;
      if ($urandom_range(0, 7) == 0) bus_item(sece_pkg::CMD_SEND, rnd_byte());
      bus_item(sece_pkg::CMD_CLOCK, rnd_byte());
    end
    bus_item(sece_pkg::CMD_DESEL, rnd_byte());
  endtask

  task automatic status_read();
    to_idle();
    bus_item(sece_pkg::CMD_SEND, opc_status);
    bus_item(sece_pkg::CMD_CLOCK, rnd_byte());
    if ($urandom_range(0, 3) == 0) bus_item(sece_pkg::CMD_CLOCK, rnd_byte());
  endtask

  // Command cut short, with clock-outs in the address phases
  task automatic broken_sequence();
    to_idle();
    bus_item(sece_pkg::CMD_SEND, $urandom_range(0, 1) ? opc_write : opc_read);
    bus_item(sece_pkg::CMD_CLOCK, rnd_byte());
    if ($urandom_range(0, 1)) begin
      bus_item(sece_pkg::CMD_SEND, rnd_byte());
      bus_item(sece_pkg::CMD_CLOCK, rnd_byte());
    end
    bus_item(sece_pkg::CMD_DESEL, rnd_byte());
  endtask

  task automatic run_traffic(input int n);
    int unsigned goal;
    int          pick;
    int          len;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 16);
        write_burst(pick_start(), len);
      end else if (pick < 65) begin
        read_burst(pick_read_start(), $urandom_range(1, 24));
      end else if (pick < 75) begin
        status_read();
      end else if (pick < 80) begin
        to_idle();
        bus_item(sece_pkg::CMD_SEND, opc_enable);
      end else if (pick < 90) begin
        broken_sequence();
      end else begin
        repeat ($urandom_range(1, 4)) bus_item(2'($urandom_range(0, 3)), rnd_byte());
      end
    end
  endtask

  task automatic randomize_opcodes(input logic [7:0] mask);
    logic [7:0] v [4];
    bit         dup;
    for (int i = 0; i < 4; i++) begin
      do begin
        v[i] = rnd_byte();
        dup  = 1'b0;
        for (int j = 0; j < i; j++) if (v[j] == v[i]) dup = 1'b1;
      end while (dup);
    end
    set_reg(sece_pkg::CFG_WRITE_OPC, v[0]);
    set_reg(sece_pkg::CFG_READ_OPC, v[1]);
    set_reg(sece_pkg::CFG_STATUS_OPC, v[2]);
    set_reg(sece_pkg::CFG_ENABLE_OPC, v[3]);
    set_reg(sece_pkg::CFG_UNLOCK, mask);
  endtask

  // Standard opcodes out of reset: status before and after unlock, 16-bit wrap
  task automatic test_reset_defaults();
    bus_item(CMD_UNUSED, 8'hFF);
    bus_item(sece_pkg::CMD_SEND, 8'h00);
    bus_item(sece_pkg::CMD_SEND, opc_status);
    bus_item(sece_pkg::CMD_CLOCK, 8'h00);
    bus_item(sece_pkg::CMD_CLOCK, 8'hFF);
    bus_item(sece_pkg::CMD_SEND, opc_enable);
    bus_item(sece_pkg::CMD_SEND, opc_status);
    bus_item(sece_pkg::CMD_CLOCK, 8'h00);
    bus_item(sece_pkg::CMD_SEND, opc_write);
    bus_item(sece_pkg::CMD_CLOCK, 8'h00);
    bus_item(sece_pkg::CMD_SEND, 8'hFF);
    bus_item(sece_pkg::CMD_SEND, 8'hFE);
    bus_item(sece_pkg::CMD_SEND, 8'hA5);
    bus_item(sece_pkg::CMD_SEND, 8'h00);
    bus_item(sece_pkg::CMD_SEND, 8'hFF);
    bus_item(sece_pkg::CMD_CLOCK, 8'hFF);
    bus_item(sece_pkg::CMD_DESEL, 8'h00);
    bus_item(sece_pkg::CMD_SEND, opc_read);
    bus_item(sece_pkg::CMD_SEND, 8'hFF);
    bus_item(sece_pkg::CMD_SEND, 8'hFE);
    bus_item(sece_pkg::CMD_SEND, 8'h3C);
    bus_item(sece_pkg::CMD_CLOCK, 8'h00);
    bus_item(sece_pkg::CMD_CLOCK, 8'hFF);
    bus_item(sece_pkg::CMD_CLOCK, 8'h00);
    bus_item(sece_pkg::CMD_DESEL, 8'hFF);
  endtask

  // Writes longer than a page fold back; reads run straight on and wrap at 64K
  task automatic test_page_wrap();
    write_burst(16'h0140, sece_pkg::PAGE_BYTES + 2);
    read_burst(16'h0140, sece_pkg::PAGE_BYTES);
    write_burst(16'hFFC0, sece_pkg::PAGE_BYTES);
    read_burst(16'hFFC0, sece_pkg::PAGE_BYTES);
  endtask

  task automatic test_opcode_extremes();
    quiesce();
    set_reg(sece_pkg::CFG_WRITE_OPC, 8'h00);
    set_reg(sece_pkg::CFG_READ_OPC, 8'hFF);
    set_reg(sece_pkg::CFG_STATUS_OPC, 8'h80);
    set_reg(sece_pkg::CFG_ENABLE_OPC, 8'h7F);
    set_reg(sece_pkg::CFG_UNLOCK, 8'h80);
    run_traffic(60);
    quiesce();
    // shared opcodes: write wins over read, status over enable
    set_reg(sece_pkg::CFG_WRITE_OPC, 8'h10);
    set_reg(sece_pkg::CFG_READ_OPC, 8'h10);
    set_reg(sece_pkg::CFG_STATUS_OPC, 8'h20);
    set_reg(sece_pkg::CFG_ENABLE_OPC, 8'h20);
    set_reg(sece_pkg::CFG_UNLOCK, 8'h00);
    for (int i = sece_pkg::CFG_UNLOCK + 1; i < (1 << sece_pkg::CFG_IDX_W); i++) begin
      set_reg(sece_pkg::CFG_IDX_W'(i), rnd_byte());
    end
    run_traffic(60);
  endtask

  task automatic test_input_backpressure();
    quiesce();
    randomize_opcodes(8'h01);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    @(posedge clk);
    hold_go = 1'b1;
    run_traffic(40);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      quiesce();
      randomize_opcodes(p == 3 ? 8'hFF : 8'(1 << $urandom_range(0, 7)));
      for (int chunk = 0; chunk < 5; chunk++) begin
        tx_gaps = (p != 3) && ($urandom_range(0, 3) != 0);
        rx_gaps = (p != 3) && ($urandom_range(0, 3) != 0);
        run_traffic(10);
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall = 1'b1;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 5);
      out_stall  = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    logic [7:0] exp_byte;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_read_data.size() == 0) begin
        $error("read_data: transfer with nothing expected, actual %02h", read_data);
        fail_count++;
      end else begin
        exp_byte = expected_read_data.pop_front();
        bytes_check++;
        if (read_data !== exp_byte) begin
          $error("read_data: expected %02h actual %02h", exp_byte, read_data);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_stall) in_held++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("spi_eeprom_command_engine_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_ni = 1'b1;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_reset_defaults();
    test_page_wrap();
    test_opcode_extremes();
    test_input_backpressure();
    test_random_traffic();
    quiesce();
    $display("Covered %0d bus items, %0d result bytes, %0d register writes;",
             items_sent, bytes_check, reg_writes);
    $display("input was held off for %0d cycles, final status %02h", in_held, status_q);
    if (fail_count == 0) begin
      $display("spi_eeprom_command_engine_top test passed");
    end else begin
      $display("spi_eeprom_command_engine_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/sece_pkg.sv
hdl/sece_front.sv
hdl/sece_queue.sv
hdl/sece_back.sv
hdl/spi_eeprom_command_engine_top.sv
verif/tb_spi_eeprom_command_engine_top.sv
